// ----- hdl/ictf_pkg.sv -----
// ictf_pkg: shared types, constants and the arctangent table for the tilt filter
// used by ictf_unit, imu_complementary_tilt_filter and ictf_chk; no dependencies
package ictf_pkg;

  localparam int unsigned DIV_W = 46;
  localparam int unsigned SQ_W  = 62;
  localparam int unsigned COR_N = 18;

  localparam logic [1:0] CFG_OFF_X  = 2'd0;
  localparam logic [1:0] CFG_OFF_Y  = 2'd1;
  localparam logic [1:0] CFG_OFF_Z  = 2'd2;
  localparam logic [1:0] CFG_WEIGHT = 2'd3;

  localparam logic [16:0] WEIGHT_RST = 17'd26;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  localparam logic [33:0] GYRO_K = 34'd16401;
  localparam logic [33:0] YAW_K  = 34'd73255;

  // reciprocals in 2^-32, exact floor quotient over the operand ranges
  localparam logic [33:0] RECIP6   = 34'd715827883;
  localparam logic [33:0] RECIP120 = 34'd35791395;

  localparam logic signed [63:0] ANG_LIM = 64'sd48318382080;
  localparam logic signed [63:0] OUT_LIM = 64'sd23040;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT, OP_CORDIC} op_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [63:0] a;
    logic [33:0] b;
  } ucmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } ursp_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic               zero_magnitude;
  } out_t;

  // arctangent of 2^-i in 2^-16 degree
  function automatic logic signed [24:0] atan_entry(input logic [4:0] idx);
    logic signed [24:0] v;
    unique case (idx)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/ictf_unit.sv -----
// ictf_unit: shared iterative unit, one step per cycle
// shift-add multiply, restoring divide, digit square root, vectoring cordic; uses ictf_pkg
module ictf_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  ictf_pkg::ucmd_t cmd,
  output ictf_pkg::ursp_t rsp
);
  import ictf_pkg::*;

  logic        busy_r;
  op_t         op_r;
  logic [63:0] acc_r;
  logic [63:0] opa_r;
  logic [33:0] opb_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [63:0] res_r;

  logic [63:0]       mul_acc;
  logic [17:0]       div_sh;
  logic [17:0]       div_den;
  logic              div_ge;
  logic [17:0]       div_rem;
  logic [DIV_W-1:0]  div_q;
  logic [34:0]       sq_sh;
  logic [34:0]       sq_trial;
  logic              sq_ge;
  logic [34:0]       sq_rem;
  logic [30:0]       sq_root;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [33:0] cdx;
  logic signed [33:0] cdy;
  logic signed [33:0] cx_nxt;
  logic signed [33:0] cy_nxt;
  logic signed [24:0] cz;
  logic signed [24:0] cz_nxt;
  logic signed [24:0] cang;

  always_comb begin
    mul_acc  = opb_r[0] ? acc_r + opa_r : acc_r;
    div_sh   = {acc_r[16:0], opa_r[DIV_W-1]};
    div_den  = {2'b00, opb_r[15:0]};
    div_ge   = div_sh >= div_den;
    div_rem  = div_ge ? div_sh - div_den : div_sh;
    div_q    = {opa_r[DIV_W-2:0], div_ge};
    sq_sh    = {acc_r[32:0], opa_r[SQ_W-1:SQ_W-2]};
    sq_trial = {2'b00, opb_r[30:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;
    sq_root  = {opb_r[29:0], sq_ge};
    cx       = $signed(acc_r[33:0]);
    cy       = $signed(opb_r);
    cz       = $signed(opa_r[24:0]);
    cdx      = cy >>> cnt_r[4:0];
    cdy      = cx >>> cnt_r[4:0];
    cang     = atan_entry(cnt_r[4:0]);
    if (cy > 34'sd0) begin
      cx_nxt = cx + cdx;
      cy_nxt = cy - cdy;
      cz_nxt = cz + cang;
    end else begin
      cx_nxt = cx - cdx;
      cy_nxt = cy + cdy;
      cz_nxt = cz - cang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (!busy_r) begin
        done_r <= 1'b0;
        if (cmd.valid) begin
          busy_r <= 1'b1;
          op_r   <= cmd.op;
          unique case (cmd.op)
            OP_MUL: begin
              cnt_r <= '0;
              acc_r <= '0;
              opa_r <= cmd.a;
              opb_r <= cmd.b;
            end
            OP_DIV: begin
              cnt_r <= 6'(DIV_W);
              acc_r <= '0;
              opa_r <= cmd.a;
              opb_r <= cmd.b;
            end
            OP_SQRT: begin
              cnt_r <= 6'(SQ_W / 2);
              acc_r <= '0;
              opa_r <= cmd.a;
              opb_r <= '0;
            end
            OP_CORDIC: begin
              cnt_r <= '0;
              acc_r <= cmd.a;
              opa_r <= '0;
              opb_r <= cmd.b;
            end
          endcase
        end
      end else begin
        unique case (op_r)
          OP_MUL: begin
            done_r <= (opb_r == '0);
            if (opb_r == '0) begin
              busy_r <= 1'b0;
              res_r  <= acc_r;
            end else begin
              acc_r <= mul_acc;
              opa_r <= opa_r << 1;
              opb_r <= opb_r >> 1;
            end
          end
          OP_DIV: begin
            acc_r  <= 64'(div_rem);
            opa_r  <= 64'(div_q);
            cnt_r  <= cnt_r - 6'd1;
            done_r <= (cnt_r == 6'd1);
            if (cnt_r == 6'd1) begin
              busy_r <= 1'b0;
              res_r  <= 64'(div_q);
            end
          end
          OP_SQRT: begin
            acc_r  <= 64'(sq_rem);
            opb_r  <= 34'(sq_root);
            opa_r  <= opa_r << 2;
            cnt_r  <= cnt_r - 6'd1;
            done_r <= (cnt_r == 6'd1);
            if (cnt_r == 6'd1) begin
              busy_r <= 1'b0;
              res_r  <= 64'(sq_root);
            end
          end
          OP_CORDIC: begin
            acc_r  <= {30'd0, cx_nxt};
            opb_r  <= cy_nxt;
            opa_r  <= {39'd0, cz_nxt};
            cnt_r  <= cnt_r + 6'd1;
            done_r <= (cnt_r == 6'(COR_N - 1));
            if (cnt_r == 6'(COR_N - 1)) begin
              busy_r <= 1'b0;
              res_r  <= 64'(cz_nxt);
            end
          end
        endcase
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

// ----- hdl/imu_complementary_tilt_filter.sv -----
// imu_complementary_tilt_filter: pitch/roll complementary filter, top level and sequencer
// depends on ictf_pkg and ictf_unit
//
//   channel   dir   handshake              payload
//   in_       in    in_valid / in_ready    in_data  (ictf_pkg::in_t)
//   out_      out   out_valid / out_ready  out_data (ictf_pkg::out_t)
//   cfg_      in    cfg_we                 cfg_index, cfg_data
//
// each word is worked through by the bit-serial shared unit: up to 26 multiply,
// divide, square root and cordic jobs run one after another
// in_ready is high only while the sequencer is idle; a finished word waits in the
// output register and the next word is taken meanwhile
// reset is synchronous active low, clears integrators and offsets and sets the weight to 26
module imu_complementary_tilt_filter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ictf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ictf_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [16:0]    cfg_data
);
  import ictf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_t;
  typedef enum logic [4:0] {
    SP_PGYRO, SP_RGYRO, SP_YAWA, SP_YAWQ, SP_YAW3, SP_YAW5, SP_DIV6, SP_DIV120,
    SP_PCPL, SP_RCPL, SP_MAGX, SP_MAGY, SP_MAGZ, SP_MAGRT,
    SP_PDIV, SP_PQSQ, SP_PISQ, SP_PCOR, SP_RDIV, SP_RQSQ, SP_RISQ, SP_RCOR,
    SP_BPG, SP_BPA, SP_BRG, SP_BRA
  } step_t;

  state_t             state_r;
  step_t              step_r;
  in_t                smp_r;
  logic signed [16:0] rx_r;
  logic signed [16:0] ry_r;
  logic signed [16:0] rz_r;
  logic signed [15:0] off_x_r;
  logic signed [15:0] off_y_r;
  logic signed [15:0] off_z_r;
  logic [16:0]        weight_r;
  logic signed [39:0] pint_r;
  logic signed [39:0] rint_r;
  logic               first_done_r;
  logic [32:0]        a_r;
  logic [29:0]        a2_r;
  logic [26:0]        a3_r;
  logic [20:0]        a5_r;
  logic [26:0]        d6_r;
  logic [25:0]        s_r;
  logic [31:0]        sum_r;
  logic [15:0]        mag_r;
  logic               zero_r;
  logic [30:0]        q_r;
  logic [60:0]        qsq_r;
  logic [30:0]        x0_r;
  logic signed [24:0] pacc_r;
  logic signed [24:0] racc_r;
  logic signed [63:0] bacc_r;
  logic signed [15:0] pout_r;
  logic signed [15:0] rout_r;
  out_t               out_r;
  logic               out_valid_r;

  ucmd_t       cmd;
  ursp_t       rsp;
  logic [16:0] w_eff;
  logic [16:0] gw;
  logic [34:0] yaw_s;
  logic [33:0] qs;
  logic [61:0] isq_rad;
  logic        job_last;

  function automatic logic [39:0] mag40(input logic signed [39:0] v);
    return v[39] ? 40'(-v) : 40'(v);
  endfunction

  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [24:0] mag25(input logic signed [24:0] v);
    return v[24] ? 25'(-v) : 25'(v);
  endfunction

  function automatic logic signed [63:0] sgn64(input logic [63:0] p, input logic neg);
    return neg ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic signed [63:0] rsh(input logic signed [63:0] v,
                                             input int unsigned n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > ANG_LIM) r = ANG_LIM;
    else if (v < -ANG_LIM) r = -ANG_LIM;
    else r = v;
    return r[39:0];
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = rsh(v, 21);
    if (r > OUT_LIM) r = OUT_LIM;
    else if (r < -OUT_LIM) r = -OUT_LIM;
    return r[15:0];
  endfunction

  ictf_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  always_comb begin
    w_eff   = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
    gw      = WEIGHT_ONE - w_eff;
    yaw_s   = 35'(a_r) - 35'(d6_r) + 35'(rsp.value[52:32]) + 35'd128;
    qs      = 34'(q_r);
    isq_rad = (62'd1 << 60) - 62'(qsq_r);
    if (step_r == SP_BRA) job_last = 1'b1;
    else if (step_r == SP_RCOR) job_last = !first_done_r;
    else if (step_r == SP_MAGRT) job_last = (rsp.value[15:0] == 16'd0) && !first_done_r;
    else job_last = 1'b0;
  end

  always_comb begin
    cmd.valid = (state_r == ST_ISSUE);
    cmd.op    = OP_MUL;
    cmd.a     = '0;
    cmd.b     = '0;
    unique case (step_r)
      SP_PGYRO: begin
        cmd.a = 64'(mag17(rx_r));
        cmd.b = GYRO_K;
      end
      SP_RGYRO: begin
        cmd.a = 64'(mag17(ry_r));
        cmd.b = GYRO_K;
      end
      SP_YAWA: begin
        cmd.a = 64'(mag17(rz_r));
        cmd.b = YAW_K;
      end
      SP_YAWQ: begin
        cmd.a = 64'(a_r[32:2]);
        cmd.b = 34'(a_r[32:2]);
      end
      SP_YAW3: begin
        cmd.a = 64'(a_r);
        cmd.b = 34'(a2_r);
      end
      SP_YAW5: begin
        cmd.a = 64'(a3_r);
        cmd.b = 34'(a2_r);
      end
      SP_DIV6: begin
        cmd.a = 64'(a3_r);
        cmd.b = RECIP6;
      end
      SP_DIV120: begin
        cmd.a = 64'(a5_r);
        cmd.b = RECIP120;
      end
      SP_PCPL: begin
        cmd.a = 64'(mag40(rint_r));
        cmd.b = 34'(s_r);
      end
      SP_RCPL: begin
        cmd.a = 64'(mag40(pint_r));
        cmd.b = 34'(s_r);
      end
      SP_MAGX: begin
        cmd.a = 64'(mag16(smp_r.accel_x));
        cmd.b = 34'(mag16(smp_r.accel_x));
      end
      SP_MAGY: begin
        cmd.a = 64'(mag16(smp_r.accel_y));
        cmd.b = 34'(mag16(smp_r.accel_y));
      end
      SP_MAGZ: begin
        cmd.a = 64'(mag16(smp_r.accel_z));
        cmd.b = 34'(mag16(smp_r.accel_z));
      end
      SP_MAGRT: begin
        cmd.op = OP_SQRT;
        cmd.a  = {sum_r, 32'd0} >> 32;
      end
      SP_PDIV: begin
        cmd.op = OP_DIV;
        cmd.a  = 64'({mag16(smp_r.accel_y), 30'd0});
        cmd.b  = 34'(mag_r);
      end
      SP_RDIV: begin
        cmd.op = OP_DIV;
        cmd.a  = 64'({mag16(smp_r.accel_x), 30'd0});
        cmd.b  = 34'(mag_r);
      end
      SP_PQSQ, SP_RQSQ: begin
        cmd.a = 64'(q_r);
        cmd.b = 34'(q_r);
      end
      SP_PISQ, SP_RISQ: begin
        cmd.op = OP_SQRT;
        cmd.a  = 64'(isq_rad);
      end
      SP_PCOR: begin
        cmd.op = OP_CORDIC;
        cmd.a  = 64'(x0_r);
        cmd.b  = smp_r.accel_y[15] ? -qs : qs;
      end
      SP_RCOR: begin
        cmd.op = OP_CORDIC;
        cmd.a  = 64'(x0_r);
        cmd.b  = smp_r.accel_x[15] ? -qs : qs;
      end
      SP_BPG: begin
        cmd.a = 64'(mag40(pint_r));
        cmd.b = 34'(gw);
      end
      SP_BPA: begin
        cmd.a = 64'(mag25(pacc_r)) << 12;
        cmd.b = 34'(w_eff);
      end
      SP_BRG: begin
        cmd.a = 64'(mag40(rint_r));
        cmd.b = 34'(gw);
      end
      SP_BRA: begin
        cmd.a = 64'(mag25(racc_r)) << 12;
        cmd.b = 34'(w_eff);
      end
      default: begin
        cmd.a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= SP_PGYRO;
      off_x_r      <= '0;
      off_y_r      <= '0;
      off_z_r      <= '0;
      weight_r     <= WEIGHT_RST;
      pint_r       <= '0;
      rint_r       <= '0;
      first_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OFF_X:  off_x_r  <= cfg_data[15:0];
          CFG_OFF_Y:  off_y_r  <= cfg_data[15:0];
          CFG_OFF_Z:  off_z_r  <= cfg_data[15:0];
          CFG_WEIGHT: weight_r <= cfg_data;
        endcase
      end
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            smp_r   <= in_data;
            rx_r    <= 17'(in_data.rate_x) - 17'(off_x_r);
            ry_r    <= 17'(in_data.rate_y) - 17'(off_y_r);
            rz_r    <= 17'(in_data.rate_z) - 17'(off_z_r);
            step_r  <= SP_PGYRO;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (rsp.done) begin
            state_r <= job_last ? ST_DONE : ST_ISSUE;
            unique case (step_r)
              SP_PGYRO: begin
                pint_r <= sat40(64'(pint_r) + sgn64(rsp.value, rx_r[16]));
                step_r <= SP_RGYRO;
              end
              SP_RGYRO: begin
                rint_r <= sat40(64'(rint_r) + sgn64(rsp.value, ry_r[16]));
                step_r <= SP_YAWA;
              end
              SP_YAWA: begin
                a_r    <= rsp.value[32:0];
                step_r <= SP_YAWQ;
              end
              SP_YAWQ: begin
                a2_r   <= rsp.value[61:32];
                step_r <= SP_YAW3;
              end
              SP_YAW3: begin
                a3_r   <= rsp.value[62:36];
                step_r <= SP_YAW5;
              end
              SP_YAW5: begin
                a5_r   <= rsp.value[56:36];
                step_r <= SP_DIV6;
              end
              SP_DIV6: begin
                d6_r   <= rsp.value[58:32];
                step_r <= SP_DIV120;
              end
              SP_DIV120: begin
                s_r    <= yaw_s[33:8];
                step_r <= SP_PCPL;
              end
              SP_PCPL: begin
                pint_r <= sat40(64'(pint_r)
                          + rsh(sgn64(rsp.value, rint_r[39] ^ rz_r[16]), 28));
                step_r <= SP_RCPL;
              end
              SP_RCPL: begin
                rint_r <= sat40(64'(rint_r)
                          - rsh(sgn64(rsp.value, pint_r[39] ^ rz_r[16]), 28));
                step_r <= SP_MAGX;
              end
              SP_MAGX: begin
                sum_r  <= rsp.value[31:0];
                step_r <= SP_MAGY;
              end
              SP_MAGY: begin
                sum_r  <= sum_r + rsp.value[31:0];
                step_r <= SP_MAGZ;
              end
              SP_MAGZ: begin
                sum_r  <= sum_r + rsp.value[31:0];
                step_r <= SP_MAGRT;
              end
              SP_MAGRT: begin
                mag_r  <= rsp.value[15:0];
                zero_r <= (rsp.value[15:0] == 16'd0);
                pacc_r <= '0;
                racc_r <= '0;
                if (rsp.value[15:0] != 16'd0) begin
                  step_r <= SP_PDIV;
                end else begin
                  step_r <= SP_BPG;
                end
              end
              SP_PDIV, SP_RDIV: begin
                q_r    <= (rsp.value[DIV_W-1:0] > (46'd1 << 30)) ? (31'd1 << 30)
                          : rsp.value[30:0];
                step_r <= (step_r == SP_PDIV) ? SP_PQSQ : SP_RQSQ;
              end
              SP_PQSQ, SP_RQSQ: begin
                qsq_r  <= rsp.value[60:0];
                step_r <= (step_r == SP_PQSQ) ? SP_PISQ : SP_RISQ;
              end
              SP_PISQ, SP_RISQ: begin
                x0_r   <= rsp.value[30:0];
                step_r <= (step_r == SP_PISQ) ? SP_PCOR : SP_RCOR;
              end
              SP_PCOR: begin
                pacc_r <= $signed(rsp.value[24:0]);
                step_r <= SP_RDIV;
              end
              SP_RCOR: begin
                racc_r <= -$signed(rsp.value[24:0]);
                step_r <= SP_BPG;
              end
              SP_BPG: begin
                bacc_r <= sgn64(rsp.value, pint_r[39]);
                step_r <= SP_BPA;
              end
              SP_BPA: begin
                pout_r <= to_out(rsh(bacc_r + sgn64(rsp.value, pacc_r[24]), 16));
                step_r <= SP_BRG;
              end
              SP_BRG: begin
                bacc_r <= sgn64(rsp.value, rint_r[39]);
                step_r <= SP_BRA;
              end
              SP_BRA: begin
                rout_r <= to_out(rsh(bacc_r + sgn64(rsp.value, racc_r[24]), 16));
              end
              default: begin
                step_r <= SP_PGYRO;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            if (first_done_r) begin
              out_r.pitch_angle <= pout_r;
              out_r.roll_angle  <= rout_r;
            end else begin
              out_r.pitch_angle <= to_out(64'(pacc_r) <<< 12);
              out_r.roll_angle  <= to_out(64'(racc_r) <<< 12);
            end
            out_r.zero_magnitude <= zero_r;
            out_valid_r  <= 1'b1;
            first_done_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/ictf_chk.sv -----
// ictf_chk: port-level checks for imu_complementary_tilt_filter, bound to the top level
// depends on ictf_pkg
module ictf_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ictf_pkg::out_t out_data
);
  import ictf_pkg::*;

  // a pending word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word dropped or changed while stalled");

  // busy after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a word");

  // a new result frees the input side
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while still busy");

  // angles stay saturated
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pitch_angle <= 16'sd23040) && (out_data.pitch_angle >= -16'sd23040)
              && (out_data.roll_angle <= 16'sd23040) && (out_data.roll_angle >= -16'sd23040))
    else $error("angle beyond limit");

endmodule

bind imu_complementary_tilt_filter ictf_chk u_ictf_chk (.*);

// ----- bench/imu_complementary_tilt_filter_tb.sv -----
// testbench for imu_complementary_tilt_filter: random and directed imu samples through
// valid/ready channels, checked against a fixed-point pitch/roll predictor
// depends on ictf_pkg and the filter rtl
module imu_complementary_tilt_filter_tb;
  import ictf_pkg::*;

  localparam longint ANGLE_LIM = 64'sd48318382080;
  localparam longint PIN_LIM   = 23040;
  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  bit          hold_off = 1'b0;
  longint      cycle_count = 0;

  always #5 clk = ~clk;

  imu_complementary_tilt_filter u_top (.*);

  class tilt_scoreboard;
    longint off_x, off_y, off_z, weight;
    longint pitch_int, roll_int;
    bit     seen_first;
    out_t   pending[$];
    int     err_count;

    function new();
      off_x = 0; off_y = 0; off_z = 0; weight = 26;
      pitch_int = 0; roll_int = 0; seen_first = 0; err_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [16:0] v);
      case (idx)
        CFG_OFF_X:  off_x = longint'($signed(v[15:0]));
        CFG_OFF_Y:  off_y = longint'($signed(v[15:0]));
        CFG_OFF_Z:  off_z = longint'($signed(v[15:0]));
        CFG_WEIGHT: weight = longint'(v);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function longint rnd_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint yaw_sine(longint rz);
      longint unsigned a, q, a2, a3, a5, s;
      longint s28;
      a = longint'(rz < 0 ? -rz : rz) * 73255;
      q = a >> 2;
      a2 = (q * q) >> 32;
      a3 = (a2 * a) >> 36;
      a5 = (a3 * a2) >> 36;
      s = a - a3 / 6 + a5 / 120;
      s28 = longint'((s + 128) >> 8);
      return rz < 0 ? -s28 : s28;
    endfunction

    function longint arcsine(longint comp, longint unsigned mag);
      longint unsigned q;
      longint x, y, z, dx, dy;
      q = (longint'(comp < 0 ? -comp : comp) << 30) / mag;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      x = longint'(int_sqrt((64'd1 << 60) - q * q));
      y = comp < 0 ? -longint'(q) : longint'(q);
      z = 0;
      for (int i = 0; i < COR_N; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += longint'(atan_entry(i[4:0]));
        end else begin
          x -= dx; y += dy; z -= longint'(atan_entry(i[4:0]));
        end
      end
      return z;
    endfunction

    function logic signed [15:0] to_angle(longint a28);
      return 16'(clamp(rnd_shift(a28, 21), PIN_LIM));
    endfunction

    function void note_sample(in_t d);
      longint ax, ay, az, rx, ry, rz, s, pacc, racc, w;
      longint unsigned mag;
      out_t e;
      ax = d.accel_x; ay = d.accel_y; az = d.accel_z;
      rx = longint'(d.rate_x) - off_x;
      ry = longint'(d.rate_y) - off_y;
      rz = longint'(d.rate_z) - off_z;
      pitch_int = clamp(pitch_int + rx * 16401, ANGLE_LIM);
      roll_int = clamp(roll_int + ry * 16401, ANGLE_LIM);
      s = yaw_sine(rz);
      pitch_int = clamp(pitch_int + rnd_shift(roll_int * s, 28), ANGLE_LIM);
      roll_int = clamp(roll_int - rnd_shift(pitch_int * s, 28), ANGLE_LIM);
      mag = int_sqrt(longint'(ax * ax + ay * ay + az * az));
      pacc = 0; racc = 0;
      e.zero_magnitude = (mag == 0);
      if (mag != 0) begin
        pacc = arcsine(ay, mag) * 4096;
        racc = -arcsine(ax, mag) * 4096;
      end
      if (!seen_first) begin
        e.pitch_angle = to_angle(pacc);
        e.roll_angle = to_angle(racc);
        seen_first = 1;
      end else begin
        w = weight > 65536 ? 65536 : weight;
        e.pitch_angle = to_angle(rnd_shift(pitch_int * (65536 - w) + pacc * w, 16));
        e.roll_angle = to_angle(rnd_shift(roll_int * (65536 - w) + racc * w, 16));
      end
      pending.push_back(e);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        err_count++;
        return;
      end
      e = pending.pop_front();
      if (got.pitch_angle !== e.pitch_angle) begin
        $error("pitch_angle expected %0d actual %0d", e.pitch_angle, got.pitch_angle);
        err_count++;
      end
      if (got.roll_angle !== e.roll_angle) begin
        $error("roll_angle expected %0d actual %0d", e.roll_angle, got.roll_angle);
        err_count++;
      end
      if (got.zero_magnitude !== e.zero_magnitude) begin
        $error("zero_magnitude expected %0d actual %0d", e.zero_magnitude,
               got.zero_magnitude);
        err_count++;
      end
    endfunction
  endclass

  tilt_scoreboard sb = new();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver readiness
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("imu_complementary_tilt_filter_tb: done, errors");
      $finish;
    end
  end

  task automatic send_word(in_t d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(16) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_sample();
    in_t d;
    d.accel_x = rand_field();
    d.accel_y = rand_field();
    d.accel_z = rand_field();
    if ($urandom_range(9) == 0) begin
      d.accel_x = 0; d.accel_y = 0; d.accel_z = 0;
    end
    d.rate_x = ($urandom_range(3) == 0) ? rand_field() : 16'($urandom_range(400) - 200);
    d.rate_y = ($urandom_range(3) == 0) ? rand_field() : 16'($urandom_range(400) - 200);
    d.rate_z = ($urandom_range(3) == 0) ? rand_field() : 16'($urandom_range(400) - 200);
    return d;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_word(rand_sample());
  endtask

  initial begin
    in_t d;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector first, then extremes and clamped ratios
    d = '0;
    send_word(d);
    d.accel_x = 16'sh8000; d.accel_y = 16'sh8000; d.accel_z = 16'sh8000;
    d.rate_x = 16'sh7fff; d.rate_y = 16'sh8000; d.rate_z = 16'sh7fff;
    send_word(d);
    d.accel_x = 16'sh7fff; d.accel_y = 16'sh7fff; d.accel_z = 16'sh7fff;
    d.rate_x = 16'sh8000; d.rate_y = 16'sh7fff; d.rate_z = 16'sh8000;
    send_word(d);
    d = '0; d.accel_y = 16'sh7fff;
    send_word(d);
    d = '0; d.accel_x = 16'sh8000;
    send_word(d);
    d = '0; d.accel_z = 16'sd1; d.rate_x = 16'sd1; d.rate_y = -16'sd1;
    send_word(d);
    for (int i = 0; i < 12; i++) begin
      d = '0;
      d.accel_z = 16'sd16384;
      d.rate_x = 16'sh7fff; d.rate_y = 16'sh7fff;
      d.rate_z = i[0] ? 16'sh8000 : 16'sh7fff;
      send_word(d);
    end
    drain();

    write_reg(CFG_OFF_X, 17'h08000);
    write_reg(CFG_OFF_Y, 17'h07fff);
    write_reg(CFG_OFF_Z, 17'h08000);
    write_reg(CFG_WEIGHT, 17'd65536);
    run_random(6);
    drain();
    write_reg(CFG_WEIGHT, 17'h1ffff);
    write_reg(CFG_OFF_X, 17'h07fff);
    write_reg(CFG_OFF_Y, 17'h08000);
    write_reg(CFG_OFF_Z, 17'h07fff);
    run_random(6);
    drain();
    write_reg(CFG_WEIGHT, 17'd0);
    write_reg(CFG_OFF_X, 17'd0);
    write_reg(CFG_OFF_Y, 17'd0);
    write_reg(CFG_OFF_Z, 17'd0);
    run_random(6);
    drain();

    // long receiver hold-off while words keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      run_random(8);
    join
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 45 : 0;
      out_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 31 : 0;
      write_reg(CFG_WEIGHT, 17'($urandom_range(65536)));
      write_reg(CFG_OFF_X, 17'($urandom_range(60) - 30));
      write_reg(CFG_OFF_Y, 17'($urandom_range(60) - 30));
      write_reg(CFG_OFF_Z, 17'($urandom_range(60) - 30));
      for (int k = 0; k < 5; k++) begin
        run_random(100);
        if ($urandom_range(3) == 0) drain();
      end
      drain();
    end

    if (sb.err_count == 0 && sb.pending.size() == 0)
      $display("imu_complementary_tilt_filter_tb: done, clean");
    else
      $display("imu_complementary_tilt_filter_tb: done, errors");
    $finish;
  end

endmodule
